FILE: rtl/core/box_blur_edge_clipped_unit_defines.svh
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Shared property forms for the box blur checkers, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_EDGE_CLIPPED_UNIT_DEFINES_SVH
`define BOX_BLUR_EDGE_CLIPPED_UNIT_DEFINES_SVH

// Same-cycle implication
`define BBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bbe_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, register indexes and lane control type.
// ----------------------------------------------------------------------------
package bbe_pkg;

    // Default sizing
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_RADIUS_DEF   = 8;
    localparam int NUM_CHANNELS_DEF = 4;

    // Pixel and port widths
    localparam int PIX_W      = 8;
    localparam int PORT_CH    = 4;
    localparam int DIV_BIT_W  = $clog2(PIX_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 16;
    localparam int RAD_BITS   = 4;
    localparam int NCH_BITS   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

    // Request commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic                 clear;
        logic                 acc;
        logic                 step;
        logic [DIV_BIT_W-1:0] bit_idx;
    } lane_ctrl_t;

endpackage

FILE: rtl/core/box_blur_edge_clipped_unit.sv
// ----------------------------------------------------------------------------
// Box blur with edge clipping
// Result path: a releasing request starts a sweep of the clipped window
//   (rows x cols, up to 17 x 17) over the row store, then a divide.
// Flow: a releasing request holds in_ready low through the sweep on the
//   single read port of the row store, the divide and the result load.
// Reset: counters clear, registers return to width 1, height 1, radius 1,
//   three channels; the row store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_edge_clipped_unit
    import bbe_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS   = MAX_RADIUS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [PIX_W-1:0]      chan0_in,
    input  logic [PIX_W-1:0]      chan1_in,
    input  logic [PIX_W-1:0]      chan2_in,
    input  logic [PIX_W-1:0]      chan3_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      chan0_out,
    output logic [PIX_W-1:0]      chan1_out,
    output logic [PIX_W-1:0]      chan2_out,
    output logic [PIX_W-1:0]      chan3_out,
    output logic                  frame_last
);

    localparam int SLOT_ROWS = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W    = $clog2(SLOT_ROWS);
    localparam int DEPTH     = SLOT_ROWS * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int SPAN_W    = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_W     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W     = PIX_W + CNT_W;
    localparam int PEND_W    = COL_W + IMG_H_BITS + 1;
    localparam int NCH_W     = $clog2(NUM_CHANNELS + 1);
    localparam int WORD_W    = PIX_W * PORT_CH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Configuration
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    logic [RAD_BITS-1:0]   radius_reg;
    logic [NCH_BITS-1:0]   nch_reg;

    logic [WID_W-1:0]      w_eff;
    logic [IMG_H_BITS-1:0] h_eff;
    logic [RAD_W-1:0]      r_eff;
    logic [NCH_W-1:0]      nch_eff;

    // Frame position
    logic [IMG_H_BITS-1:0] in_row_reg;
    logic [COL_W-1:0]      in_col_reg;
    logic [SLOT_W-1:0]     in_slot_reg;
    logic [IMG_H_BITS-1:0] out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [PEND_W-1:0]     pend_reg;
    logic [PEND_W-1:0]     lag;

    // Sequencer and window sweep
    logic [2:0]            state_reg;
    logic [SLOT_W-1:0]     sw_slot_reg;
    logic [COL_W-1:0]      sw_col_reg;
    logic [COL_W-1:0]      sw_c0_reg;
    logic [SPAN_W-1:0]     sw_xleft_reg;
    logic [SPAN_W-1:0]     sw_yleft_reg;
    logic [SPAN_W-1:0]     sw_ncols_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  last_reg;
    logic [DIV_BIT_W-1:0]  bit_reg;
    logic                  rd_vld_reg;

    // Row store
    logic [WORD_W-1:0]     mem [DEPTH];
    logic [WORD_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    // Window geometry
    logic [RAD_W-1:0]        above;
    logic [RAD_W-1:0]        below;
    logic [RAD_W-1:0]        left_n;
    logic [RAD_W-1:0]        right_n;
    logic [IMG_H_BITS-1:0]   row_dist;
    logic [WID_W-1:0]        col_dist;
    logic [SPAN_W-1:0]       nrows;
    logic [SPAN_W-1:0]       ncols;
    logic [2*SPAN_W-1:0]     area;
    logic [SLOT_W:0]         slot_sum;
    logic [SLOT_W-1:0]       start_slot;
    logic                    is_last;

    // Request decode
    logic in_acc;
    logic in_done;
    logic do_write;
    logic emit;

    logic             merge_free;
    logic             merge_load;
    lane_ctrl_t       lane_ctrl;
    logic [PIX_W-1:0] quot [NUM_CHANNELS];
    logic [PIX_W-1:0] chan_out [PORT_CH];

    // Clamp register values to their working ranges
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WID_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = WID_W'(width_reg);

        h_eff = (height_reg == '0) ? IMG_H_BITS'(1) : height_reg;

        if (radius_reg == '0)
            r_eff = RAD_W'(1);
        else if (32'(radius_reg) > MAX_RADIUS)
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = RAD_W'(radius_reg);

        if (nch_reg == '0)
            nch_eff = NCH_W'(1);
        else if (32'(nch_reg) > NUM_CHANNELS)
            nch_eff = NCH_W'(NUM_CHANNELS);
        else
            nch_eff = NCH_W'(nch_reg);
    end

    assign lag = PEND_W'(r_eff) * PEND_W'(w_eff) + PEND_W'(r_eff);

    // Decode the request
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign in_done  = (in_row_reg >= h_eff);
    assign do_write = in_acc && (command == CMD_SAMPLE) && !in_done;
    assign emit     = in_acc && (in_done || (do_write && (pend_reg >= lag)));

    // Clip the window around the next output position
    always_comb
    begin
        row_dist = h_eff - out_row_reg - IMG_H_BITS'(1);
        col_dist = w_eff - WID_W'(out_col_reg) - WID_W'(1);
        above    = (32'(out_row_reg) < 32'(r_eff)) ? RAD_W'(out_row_reg) : r_eff;
        below    = (32'(row_dist) < 32'(r_eff)) ? RAD_W'(row_dist) : r_eff;
        left_n   = (32'(out_col_reg) < 32'(r_eff)) ? RAD_W'(out_col_reg) : r_eff;
        right_n  = (32'(col_dist) < 32'(r_eff)) ? RAD_W'(col_dist) : r_eff;
        nrows    = SPAN_W'(above) + SPAN_W'(below) + SPAN_W'(1);
        ncols    = SPAN_W'(left_n) + SPAN_W'(right_n) + SPAN_W'(1);
        area     = (2*SPAN_W)'(nrows) * (2*SPAN_W)'(ncols);
        slot_sum = (SLOT_W+1)'(out_slot_reg) + (SLOT_W+1)'(SLOT_ROWS) - (SLOT_W+1)'(above);
        if (slot_sum >= (SLOT_W+1)'(SLOT_ROWS))
            start_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(SLOT_ROWS));
        else
            start_slot = SLOT_W'(slot_sum);
        is_last  = (32'(out_row_reg) + 1 >= 32'(h_eff))
                && (32'(out_col_reg) + 1 >= 32'(w_eff));
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_W_BITS'(1);
            height_reg <= IMG_H_BITS'(1);
            radius_reg <= RAD_BITS'(1);
            nch_reg    <= NCH_BITS'(3);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[IMG_H_BITS-1:0];
                REG_BLUR_RADIUS:   radius_reg <= cfg_data[RAD_BITS-1:0];
                REG_CHANNEL_COUNT: nch_reg    <= cfg_data[NCH_BITS-1:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Advance frame positions; restart on a register write or the last output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
        end
        else if (cfg_write_en || (emit && is_last))
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (do_write)
            begin
                if (32'(in_col_reg) + 1 >= 32'(w_eff))
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + IMG_H_BITS'(1);
                    if (32'(in_slot_reg) == SLOT_ROWS - 1)
                        in_slot_reg <= '0;
                    else
                        in_slot_reg <= in_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (emit)
            begin
                if (32'(out_col_reg) + 1 >= 32'(w_eff))
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + IMG_H_BITS'(1);
                    if (32'(out_slot_reg) == SLOT_ROWS - 1)
                        out_slot_reg <= '0;
                    else
                        out_slot_reg <= out_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
            if (do_write && !emit)
                pend_reg <= pend_reg + PEND_W'(1);
            else if (!do_write && emit)
                pend_reg <= pend_reg - PEND_W'(1);
        end
    end

    // Row store: one write port, one registered read port
    assign wr_addr = ADDR_W'(in_slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg);
    assign rd_addr = ADDR_W'(sw_slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sw_col_reg);

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_addr] <= {chan3_in, chan2_in, chan1_in, chan0_in};
        rd_data_reg <= mem[rd_addr];
    end

    // Sequence the window sweep and the divide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == ST_READ);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (emit)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    if ((sw_xleft_reg == '0) && (sw_yleft_reg == '0))
                        state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    bit_reg   <= DIV_BIT_W'(PIX_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (bit_reg == '0)
                        state_reg <= ST_DONE;
                    else
                        bit_reg <= bit_reg - DIV_BIT_W'(1);
                end
                ST_DONE:
                begin
                    if (merge_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Latch the window and walk it row by row
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sw_slot_reg  <= start_slot;
            sw_col_reg   <= out_col_reg - COL_W'(left_n);
            sw_c0_reg    <= out_col_reg - COL_W'(left_n);
            sw_xleft_reg <= ncols - SPAN_W'(1);
            sw_yleft_reg <= nrows - SPAN_W'(1);
            sw_ncols_reg <= ncols;
            cnt_reg      <= CNT_W'(area);
            last_reg     <= is_last;
        end
        else if (state_reg == ST_READ)
        begin
            if (sw_xleft_reg == '0)
            begin
                if (sw_yleft_reg != '0)
                begin
                    sw_yleft_reg <= sw_yleft_reg - SPAN_W'(1);
                    sw_col_reg   <= sw_c0_reg;
                    sw_xleft_reg <= sw_ncols_reg - SPAN_W'(1);
                    if (32'(sw_slot_reg) == SLOT_ROWS - 1)
                        sw_slot_reg <= '0;
                    else
                        sw_slot_reg <= sw_slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                sw_col_reg   <= sw_col_reg + COL_W'(1);
                sw_xleft_reg <= sw_xleft_reg - SPAN_W'(1);
            end
        end
    end

    // Drive the lanes
    assign lane_ctrl.clear   = emit;
    assign lane_ctrl.acc     = rd_vld_reg;
    assign lane_ctrl.step    = (state_reg == ST_DIV);
    assign lane_ctrl.bit_idx = bit_reg;

    for (genvar k = 0; k < NUM_CHANNELS; k++)
    begin : g_lane
        bbe_lane #(
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .pix  (rd_data_reg[PIX_W*k +: PIX_W]),
            .cnt  (cnt_reg),
            .quot (quot[k])
        );
    end

    assign merge_load = (state_reg == ST_DONE) && merge_free;

    bbe_merge #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NCH_W        (NCH_W)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (merge_load),
        .last_in    (last_reg),
        .nch        (nch_eff),
        .quot       (quot),
        .out_ready  (out_ready),
        .free       (merge_free),
        .out_valid  (out_valid),
        .frame_last (frame_last),
        .chan_out   (chan_out)
    );

    assign chan0_out = chan_out[0];
    assign chan1_out = chan_out[1];
    assign chan2_out = chan_out[2];
    assign chan3_out = chan_out[3];

endmodule

FILE: rtl/core/bbe_lane.sv
// ----------------------------------------------------------------------------
// Box blur channel lane
// Accumulates one channel over the window, then divides the sum by the
// pixel count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbe_lane
    import bbe_pkg::*;
#(
    parameter int CNT_W = 9,
    parameter int SUM_W = 17
)
(
    input  logic             clk,
    input  lane_ctrl_t       ctrl,
    input  logic [PIX_W-1:0] pix,
    input  logic [CNT_W-1:0] cnt,
    output logic [PIX_W-1:0] quot
);

    localparam int TRY_W = SUM_W + PIX_W;

    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] rem_next;
    logic [PIX_W-1:0] q_reg;
    logic [PIX_W-1:0] q_next;
    logic [TRY_W-1:0] trial;

    // Shifted divisor for the current quotient bit
    assign trial = TRY_W'(cnt) << ctrl.bit_idx;

    // Clear, accumulate or take one restoring divide step
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (ctrl.clear)
        begin
            rem_next = '0;
            q_next   = '0;
        end
        else if (ctrl.acc)
        begin
            rem_next = rem_reg + SUM_W'(pix);
        end
        else if (ctrl.step)
        begin
            if (TRY_W'(rem_reg) >= trial)
            begin
                rem_next = SUM_W'(TRY_W'(rem_reg) - trial);
                q_next[ctrl.bit_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;

endmodule

FILE: rtl/core/bbe_merge.sv
// ----------------------------------------------------------------------------
// Box blur lane merge
// Gathers the lane quotients, zeroes unused channels and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module bbe_merge
    import bbe_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int NCH_W        = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             last_in,
    input  logic [NCH_W-1:0] nch,
    input  logic [PIX_W-1:0] quot [NUM_CHANNELS],
    input  logic             out_ready,
    output logic             free,
    output logic             out_valid,
    output logic             frame_last,
    output logic [PIX_W-1:0] chan_out [PORT_CH]
);

    logic             valid_reg;
    logic             last_reg;
    logic [PIX_W-1:0] chan_reg  [PORT_CH];
    logic [PIX_W-1:0] chan_next [PORT_CH];

    // Select active channels, zero the rest
    for (genvar k = 0; k < PORT_CH; k++)
    begin : g_ch
        if (k < NUM_CHANNELS)
        begin : g_used
            assign chan_next[k] = (32'(nch) > k) ? quot[k] : '0;
        end
        else
        begin : g_unused
            assign chan_next[k] = '0;
        end
    end

    assign free = !valid_reg || out_ready;

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= last_in;
            chan_reg <= chan_next;
        end
    end

    assign out_valid  = valid_reg;
    assign frame_last = last_reg;
    assign chan_out   = chan_reg;

endmodule

FILE: rtl/core/bbe_checker.sv
// ----------------------------------------------------------------------------
// Box blur port checker
// Watches the top level ports for result timing and output hold.
// ----------------------------------------------------------------------------
`include "box_blur_edge_clipped_unit_defines.svh"

module bbe_checker
    import bbe_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] chan0_out,
    input logic [PIX_W-1:0] chan1_out,
    input logic [PIX_W-1:0] chan2_out,
    input logic [PIX_W-1:0] chan3_out,
    input logic             frame_last
);

    // Hold a stalled result
    `BBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(chan0_out) && $stable(chan1_out) && $stable(chan2_out) && $stable(chan3_out) && $stable(frame_last), "stalled result changed")

    // A new result appears only after the sequencer was busy
    `BBE_ASSERT_SAME(a_rise_busy, $rose(out_valid), !$past(in_ready), "result appeared while idle")

    // No result directly after a request
    `BBE_ASSERT_NEXT(a_no_fast, in_valid && in_ready && !out_valid, !out_valid, "result one cycle after request")

endmodule

bind box_blur_edge_clipped_unit bbe_checker u_bbe_checker (.*);

FILE: verif/box_blur_edge_clipped_unit_test.sv
// ----------------------------------------------------------------------------
// Box blur with edge clipping: self-checking test
// Configures a series of frame shapes, streams pixel and drain requests into
// the block under random idling and a long output stall, and compares each
// blurred pixel with a local prediction of the clipped-window mean.
// ----------------------------------------------------------------------------
module box_blur_edge_clipped_unit_test;
    import bbe_pkg::*;

    localparam int LINE_SLOTS = 2 * MAX_RADIUS_DEF + 2;
    localparam int SETTLE_CYC = 400;

    typedef struct packed {
        logic                     cmd;
        logic [3:0][PIX_W-1:0]    px;
    } blur_req_t;

    typedef struct packed {
        logic [3:0][PIX_W-1:0]    px;
        logic                     last;
    } blur_pix_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  command = CMD_SAMPLE;
    logic [PIX_W-1:0]      chan0_in = '0;
    logic [PIX_W-1:0]      chan1_in = '0;
    logic [PIX_W-1:0]      chan2_in = '0;
    logic [PIX_W-1:0]      chan3_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      chan0_out;
    logic [PIX_W-1:0]      chan1_out;
    logic [PIX_W-1:0]      chan2_out;
    logic [PIX_W-1:0]      chan3_out;
    logic                  frame_last;

    blur_req_t   request_q[$];
    blur_pix_t   blurred_q[$];
    blur_req_t   held_req;
    int unsigned accepted_cnt = 0;
    int unsigned queued_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          steady = 1'b0;

    // Predictor state
    logic [31:0] line_mem [LINE_SLOTS * MAX_WIDTH_DEF];
    int unsigned reg_w = 1, reg_h = 1, reg_r = 1, reg_nch = 3;
    int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;

    box_blur_edge_clipped_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .chan0_in(chan0_in), .chan1_in(chan1_in), .chan2_in(chan2_in),
        .chan3_in(chan3_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .chan0_out(chan0_out), .chan1_out(chan1_out), .chan2_out(chan2_out),
        .chan3_out(chan3_out), .frame_last(frame_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Mean over the clipped window at the output position, then advance it
    function automatic blur_pix_t blur_at(int unsigned w, int unsigned h,
                                          int unsigned r, int unsigned nch);
        blur_pix_t   res;
        int unsigned r0, r1, c0, c1, cnt;
        int unsigned acc[4];
        logic [31:0] px;
        r0 = (out_row >= r) ? out_row - r : 0;
        r1 = (out_row + r < h) ? out_row + r : h - 1;
        c0 = (out_col >= r) ? out_col - r : 0;
        c1 = (out_col + r < w) ? out_col + r : w - 1;
        cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
        acc = '{0, 0, 0, 0};
        for (int unsigned y = r0; y <= r1; y++)
            for (int unsigned x = c0; x <= c1; x++)
            begin
                px = line_mem[(y % LINE_SLOTS) * MAX_WIDTH_DEF + x];
                for (int ch = 0; ch < 4; ch++)
                    acc[ch] += px[8*ch +: 8];
            end
        for (int ch = 0; ch < 4; ch++)
            res.px[ch] = (ch < nch) ? PIX_W'(acc[ch] / cnt) : '0;
        res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (res.last)
        begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row = out_row + 1;
        end
        else
            out_col = out_col + 1;
        return res;
    endfunction

    // Apply one accepted request to the predictor
    function automatic void blur_step(blur_req_t q);
        int unsigned w, h, r, nch, total, lag, in_idx, out_idx;
        w = clip(reg_w, 1, MAX_WIDTH_DEF);
        h = clip(reg_h, 1, 65535);
        r = clip(reg_r, 1, MAX_RADIUS_DEF);
        nch = clip(reg_nch, 1, NUM_CHANNELS_DEF);
        total = w * h;
        lag = r * w + r;
        in_idx = in_row * w + in_col;
        out_idx = out_row * w + out_col;
        if (q.cmd == CMD_SAMPLE && in_idx < total)
        begin
            line_mem[(in_row % LINE_SLOTS) * MAX_WIDTH_DEF + in_col] = q.px;
            if (in_col + 1 >= w)
            begin
                in_col = 0;
                in_row = in_row + 1;
            end
            else
                in_col = in_col + 1;
            in_idx++;
            if (out_idx < total && in_idx >= out_idx + lag + 1)
                blurred_q.push_back(blur_at(w, h, r, nch));
        end
        else if (in_idx >= total && out_idx < total)
            blurred_q.push_back(blur_at(w, h, r, nch));
    endfunction

    // Drive requests; predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                blur_step(held_req);
                accepted_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (request_q.size() > 0 && (steady || $urandom_range(99) >= 37))
                begin
                    held_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    command  <= held_req.cmd;
                    chan0_in <= held_req.px[0];
                    chan1_in <= held_req.px[1];
                    chan2_in <= held_req.px[2];
                    chan3_in <= held_req.px[3];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output ready: random, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= 400)
        begin
            hold_done <= 1'b1;
            hold_left <= 1500;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 37);
    end

    // Compare each delivered pixel with the oldest prediction
    always @(posedge clk)
    begin
        blur_pix_t exp_pix;
        logic [3:0][PIX_W-1:0] got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {chan3_out, chan2_out, chan1_out, chan0_out};
            if (blurred_q.size() == 0)
            begin
                $error("unexpected output pixel");
                fail_cnt++;
            end
            else
            begin
                exp_pix = blurred_q.pop_front();
                for (int ch = 0; ch < 4; ch++)
                    if (got[ch] !== exp_pix.px[ch])
                    begin
                        $error("chan%0d_out expected %0d got %0d", ch, exp_pix.px[ch], got[ch]);
                        fail_cnt++;
                    end
                if (frame_last !== exp_pix.last)
                begin
                    $error("frame_last expected %0d got %0d", exp_pix.last, frame_last);
                    fail_cnt++;
                end
            end
        end
    end

    // Wait until every request is taken and every pixel delivered
    task automatic settle();
        while (request_q.size() > 0 || in_valid || blurred_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic write_regs(int unsigned w, int unsigned h, int unsigned r, int unsigned n);
        int unsigned vals[4];
        logic [CFG_IDX_W-1:0] idx[4];
        vals = '{w, h, r, n};
        idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BLUR_RADIUS, REG_CHANNEL_COUNT};
        for (int k = 0; k < 4; k++)
        begin
            @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index    <= idx[k];
            cfg_data     <= CFG_DATA_W'(vals[k]);
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
        reg_w   = w & 32'h7FF;
        reg_h   = h & 32'hFFFF;
        reg_r   = r & 32'hF;
        reg_nch = n & 32'h7;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endtask

    function automatic blur_req_t make_req(logic cmd, bit extremes);
        blur_req_t q;
        q.cmd = cmd;
        for (int ch = 0; ch < 4; ch++)
            q.px[ch] = extremes ? PIX_W'($urandom_range(1) * 255) : PIX_W'($urandom);
        return q;
    endfunction

    // Configure one frame and queue its pixels, stray drains and flushing drains
    task automatic run_frame(int unsigned w_raw, int unsigned h_raw, int unsigned r_raw,
                             int unsigned n_raw, int unsigned pix_cap, bit extremes,
                             int unsigned noise);
        int unsigned w, h, r, total, lag, npix, pend;
        settle();
        write_regs(w_raw, h_raw, r_raw, n_raw);
        w = clip(w_raw & 32'h7FF, 1, MAX_WIDTH_DEF);
        h = clip(h_raw & 32'hFFFF, 1, 65535);
        r = clip(r_raw & 32'hF, 1, MAX_RADIUS_DEF);
        total = w * h;
        lag = r * w + r;
        npix = (total < pix_cap) ? total : pix_cap;
        pend = (npix == total) ? ((total < lag) ? total : lag) : 0;
        for (int unsigned i = 0; i < npix; i++)
        begin
            if (i + 1 < npix && $urandom_range(99) < noise)
                request_q.push_back(make_req(CMD_DRAIN, extremes));
            request_q.push_back(make_req(CMD_SAMPLE, extremes));
        end
        // Flush: a sample past the frame end acts as a drain
        for (int unsigned i = 0; i < pend; i++)
            request_q.push_back(make_req(($urandom_range(99) < noise) ? CMD_SAMPLE
                                                                      : CMD_DRAIN, extremes));
        queued_cnt += npix + pend;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset shape, then a small frame of extreme values
        request_q.push_back(make_req(CMD_SAMPLE, 1'b1));
        request_q.push_back(make_req(CMD_DRAIN, 1'b1));
        run_frame(4, 3, 1, 4, 100, 1'b1, 30);
        // Out-of-range registers: zero sizes and oversize width, radius, channels
        run_frame(0, 0, 0, 0, 100, 1'b1, 0);
        run_frame(7, 5, 15, 7, 100, 1'b0, 20);
        run_frame(1, 65535, 8, 2, 60, 1'b0, 10);
        steady = 1'b1;
        run_frame(16, 12, 2, 4, 1000, 1'b0, 5);
        settle();
        steady = 1'b0;
        run_frame(2047, 1, 15, 7, 300, 1'b0, 5);

        // Random frames
        while (queued_cnt < 1200)
            run_frame($urandom_range(1, 24), $urandom_range(1, 16),
                      ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
                      $urandom_range(7), 1000, $urandom_range(3) == 0, 8);

        settle();
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
